// ----- sv/software_timer_queue_macros.svh -----
// assertion macros for the software timer queue
`ifndef SOFTWARE_TIMER_QUEUE_MACROS_SVH
`define SOFTWARE_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stq assertion failed");
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stq assertion failed");
`else
`define STQ_ASSERT_IMPL(lbl, ante, cons)
`define STQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/stq_pkg.sv -----
// shared codes and control types for the software timer queue
package stq_pkg;

    localparam logic [2:0] REQ_ALLOC = 3'd0;
    localparam logic [2:0] REQ_FREE  = 3'd1;
    localparam logic [2:0] REQ_BIND  = 3'd2;
    localparam logic [2:0] REQ_ARM   = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_EXPIRED  = 3'd4;

    localparam logic [1:0] FL_FREE  = 2'd0;
    localparam logic [1:0] FL_ALLOC = 2'd1;
    localparam logic [1:0] FL_RUN   = 2'd2;

    typedef enum logic [1:0] {
        FA_ID   = 2'd0,
        FA_IDX  = 2'd1,
        FA_HEAD = 2'd2
    } flag_sel_t;

    typedef enum logic [1:0] {
        LW_ID_NULL = 2'd0,
        LW_ID_CUR  = 2'd1,
        LW_PREV_ID = 2'd2,
        LW_CUR_ID  = 2'd3
    } link_sel_t;

    typedef struct packed {
        logic       latch_in;
        logic       flag_wr;
        logic [1:0] flag_val;
        flag_sel_t  flag_sel;
        logic       rd_head;
        logic       idx_clr;
        logic       idx_inc;
        logic       bind_wr;
        logic       dl_wr;
        logic       link_wr;
        link_sel_t  link_sel;
        logic       head_ld_id;
        logic       head_ld_next;
        logic       cur_ld_head;
        logic       cur_ld_next;
        logic       prev_clr;
        logic       prev_ld_cur;
        logic       pend_ld;
        logic       pend_clr;
        logic       out_ld;
        logic [2:0] out_status;
        logic       out_last;
    } stq_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       id_ok;
        logic       id_run;
        logic       head_null;
        logic       idx_free;
        logic       idx_last;
        logic       arm_le;
        logic       next_null;
        logic       prev_null;
        logic       expire;
        logic       pend_valid;
        logic       out_busy;
    } stq_stat_t;

endpackage

// ----- sv/stq_datapath.sv -----
// timer storage, sorted list pointers, tick counter and output register
module stq_datapath #(
    parameter int NUM_TIMERS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [79:0]       s_tdata,   // timer_id, timeout, dest_queue, data_tag, zero pad
    input  logic [2:0]        s_tuser,   // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // slot, event_queue, event_data, zero pad
    output logic [2:0]        m_tuser,   // status
    output logic              m_tlast,
    input  stq_pkg::stq_cmd_t cmd,
    output stq_pkg::stq_stat_t st
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IW:0] LINK_NULL = {1'b1, {IW{1'b0}}};
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_TIMERS - 1);
    localparam logic [6:0] NUM_T7 = 7'(NUM_TIMERS);

    logic [1:0]  flags_mem [NUM_TIMERS];
    logic [31:0] dl_mem    [NUM_TIMERS];
    logic [3:0]  q_mem     [NUM_TIMERS];
    logic [31:0] data_mem  [NUM_TIMERS];
    logic [IW:0] link_mem  [NUM_TIMERS];

    logic [2:0]    req_reg;
    logic [5:0]    id_reg;
    logic [3:0]    q_in_reg;
    logic [31:0]   data_in_reg;
    logic [31:0]   d_reg;
    logic [31:0]   tick_reg;
    logic [IW:0]   head_reg;
    logic [IW:0]   cur_reg;
    logic [IW:0]   prev_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          pend_valid_reg;
    logic [IW-1:0] pend_slot_reg;
    logic [3:0]    pend_q_reg;
    logic [31:0]   pend_data_reg;

    logic [1:0]  flag_rd;
    logic [31:0] dl_rd;
    logic [IW:0] link_rd;
    logic [3:0]  q_rd;
    logic [31:0] data_rd;

    logic          m_tvalid_reg;
    logic [2:0]    out_status_reg;
    logic [5:0]    out_slot_reg;
    logic [3:0]    out_q_reg;
    logic [31:0]   out_data_reg;
    logic          out_last_reg;

    logic [IW-1:0] id_a;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] flag_addr;
    logic [IW-1:0] flag_rd_addr;
    logic [IW-1:0] link_addr;
    logic [IW:0]   link_data;

    assign id_a    = id_reg[IW-1:0];
    assign rd_addr = cmd.rd_head ? head_reg[IW-1:0] : cur_reg[IW-1:0];

    always_comb begin
        unique case (cmd.flag_sel)
            stq_pkg::FA_IDX:  flag_addr = idx_reg;
            stq_pkg::FA_HEAD: flag_addr = head_reg[IW-1:0];
            default:          flag_addr = id_a;
        endcase
    end

    // flag read runs ahead: the incoming id at accept, the next scan index while scanning, else the latched id
    always_comb begin
        if (cmd.latch_in) begin
            flag_rd_addr = s_tdata[IW-1:0];
        end else if (cmd.flag_sel == stq_pkg::FA_IDX) begin
            flag_rd_addr = idx_next;
        end else begin
            flag_rd_addr = id_a;
        end
    end

    always_comb begin
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_comb begin
        unique case (cmd.link_sel)
            stq_pkg::LW_ID_NULL: begin
                link_addr = id_a;
                link_data = LINK_NULL;
            end
            stq_pkg::LW_ID_CUR: begin
                link_addr = id_a;
                link_data = cur_reg;
            end
            stq_pkg::LW_PREV_ID: begin
                link_addr = prev_reg[IW-1:0];
                link_data = {1'b0, id_a};
            end
            default: begin
                link_addr = cur_reg[IW-1:0];
                link_data = {1'b0, id_a};
            end
        endcase
    end

    // slot flags
    always_ff @(posedge aclk) begin
        if (cmd.flag_wr) begin
            flags_mem[flag_addr] <= cmd.flag_val;
        end
        flag_rd <= flags_mem[flag_rd_addr];
    end

    // timer memories
    always_ff @(posedge aclk) begin
        if (cmd.dl_wr) begin
            dl_mem[id_a] <= d_reg;
        end
        if (cmd.bind_wr) begin
            q_mem[id_a]    <= q_in_reg;
            data_mem[id_a] <= data_in_reg;
        end
        if (cmd.link_wr) begin
            link_mem[link_addr] <= link_data;
        end
        dl_rd   <= dl_mem[rd_addr];
        link_rd <= link_mem[rd_addr];
        q_rd    <= q_mem[rd_addr];
        data_rd <= data_mem[rd_addr];
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            req_reg     <= s_tuser;
            id_reg      <= s_tdata[5:0];
            q_in_reg    <= s_tdata[41:38];
            data_in_reg <= s_tdata[73:42];
            d_reg       <= tick_reg + s_tdata[37:6];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            head_reg       <= LINK_NULL;
            cur_reg        <= LINK_NULL;
            prev_reg       <= LINK_NULL;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.latch_in && s_tuser == stq_pkg::REQ_TICK) begin
                tick_reg <= tick_reg + 32'd1;
            end
            if (cmd.head_ld_id) begin
                head_reg <= {1'b0, id_a};
            end else if (cmd.head_ld_next) begin
                head_reg <= link_rd;
            end
            if (cmd.cur_ld_head) begin
                cur_reg <= head_reg;
            end else if (cmd.cur_ld_next) begin
                cur_reg <= link_rd;
            end
            if (cmd.prev_clr) begin
                prev_reg <= LINK_NULL;
            end else if (cmd.prev_ld_cur) begin
                prev_reg <= cur_reg;
            end
            idx_reg <= idx_next;
            if (cmd.pend_ld) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.pend_clr) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_ld) begin
            pend_slot_reg <= head_reg[IW-1:0];
            pend_q_reg    <= q_rd;
            pend_data_reg <= data_rd;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
            if (cmd.out_status == stq_pkg::ST_EXPIRED) begin
                out_slot_reg <= 6'(pend_slot_reg);
                out_q_reg    <= pend_q_reg;
                out_data_reg <= pend_data_reg;
            end else if (cmd.out_status == stq_pkg::ST_GRANTED) begin
                out_slot_reg <= 6'(idx_reg);
                out_q_reg    <= '0;
                out_data_reg <= '0;
            end else begin
                out_slot_reg <= '0;
                out_q_reg    <= '0;
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, out_data_reg, out_q_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

    assign st.req        = req_reg;
    assign st.id_ok      = {1'b0, id_reg} < NUM_T7;
    assign st.id_run     = flag_rd == stq_pkg::FL_RUN;
    assign st.head_null  = head_reg[IW];
    assign st.idx_free   = flag_rd == stq_pkg::FL_FREE;
    assign st.idx_last   = idx_reg == IDX_LAST;
    assign st.arm_le     = d_reg <= dl_rd;
    assign st.next_null  = link_rd[IW];
    assign st.prev_null  = prev_reg[IW];
    assign st.expire     = !head_reg[IW] && (dl_rd <= tick_reg);
    assign st.pend_valid = pend_valid_reg;
    assign st.out_busy   = m_tvalid_reg && !m_tready;

endmodule

// ----- sv/stq_ctrl.sv -----
// request sequencer for the software timer queue
module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  stq_pkg::stq_stat_t st,
    output stq_pkg::stq_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_INIT     = 9'b0_0000_0001,
        S_IDLE     = 9'b0_0000_0010,
        S_DECODE   = 9'b0_0000_0100,
        S_ALLOC    = 9'b0_0000_1000,
        S_ARM_RD   = 9'b0_0001_0000,
        S_ARM_CMP  = 9'b0_0010_0000,
        S_ARM_FIX  = 9'b0_0100_0000,
        S_TICK_RD  = 9'b0_1000_0000,
        S_TICK_CHK = 9'b1_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                // mark every slot free, one per cycle
                cmd.flag_wr  = 1'b1;
                cmd.flag_val = stq_pkg::FL_FREE;
                cmd.flag_sel = stq_pkg::FA_IDX;
                if (st.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!st.out_busy) begin
                    case (st.req)
                        stq_pkg::REQ_ALLOC: begin
                            cmd.idx_clr  = 1'b1;
                            cmd.flag_sel = stq_pkg::FA_IDX;
                            state_next   = S_ALLOC;
                        end
                        stq_pkg::REQ_TICK: begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_TICK_RD;
                        end
                        stq_pkg::REQ_FREE: begin
                            cmd.out_ld   = 1'b1;
                            cmd.out_last = 1'b1;
                            state_next   = S_IDLE;
                            if (!st.id_ok || st.id_run) begin
                                cmd.out_status = stq_pkg::ST_REJECTED;
                            end else begin
                                cmd.flag_wr    = 1'b1;
                                cmd.flag_val   = stq_pkg::FL_FREE;
                                cmd.flag_sel   = stq_pkg::FA_ID;
                                cmd.out_status = stq_pkg::ST_DONE;
                            end
                        end
                        stq_pkg::REQ_BIND: begin
                            cmd.out_ld   = 1'b1;
                            cmd.out_last = 1'b1;
                            state_next   = S_IDLE;
                            if (!st.id_ok) begin
                                cmd.out_status = stq_pkg::ST_REJECTED;
                            end else begin
                                cmd.bind_wr    = 1'b1;
                                cmd.out_status = stq_pkg::ST_DONE;
                            end
                        end
                        stq_pkg::REQ_ARM: begin
                            if (!st.id_ok || st.id_run) begin
                                cmd.out_ld     = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = stq_pkg::ST_REJECTED;
                                state_next     = S_IDLE;
                            end else begin
                                cmd.dl_wr    = 1'b1;
                                cmd.flag_wr  = 1'b1;
                                cmd.flag_val = stq_pkg::FL_RUN;
                                cmd.flag_sel = stq_pkg::FA_ID;
                                if (st.head_null) begin
                                    cmd.link_wr    = 1'b1;
                                    cmd.link_sel   = stq_pkg::LW_ID_NULL;
                                    cmd.head_ld_id = 1'b1;
                                    cmd.out_ld     = 1'b1;
                                    cmd.out_last   = 1'b1;
                                    cmd.out_status = stq_pkg::ST_DONE;
                                    state_next     = S_IDLE;
                                end else begin
                                    cmd.cur_ld_head = 1'b1;
                                    cmd.prev_clr    = 1'b1;
                                    state_next      = S_ARM_RD;
                                end
                            end
                        end
                        default: begin
                            cmd.out_ld     = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = stq_pkg::ST_REJECTED;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                cmd.flag_sel = stq_pkg::FA_IDX;
                if (!st.out_busy) begin
                    if (st.idx_free) begin
                        cmd.flag_wr    = 1'b1;
                        cmd.flag_val   = stq_pkg::FL_ALLOC;
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = stq_pkg::ST_GRANTED;
                        state_next     = S_IDLE;
                    end else if (st.idx_last) begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = stq_pkg::ST_NONE;
                        state_next     = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_ARM_RD: begin
                state_next = S_ARM_CMP;
            end
            S_ARM_CMP: begin
                if (st.arm_le) begin
                    if (st.prev_null) begin
                        if (!st.out_busy) begin
                            cmd.link_wr    = 1'b1;
                            cmd.link_sel   = stq_pkg::LW_ID_CUR;
                            cmd.head_ld_id = 1'b1;
                            cmd.out_ld     = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = stq_pkg::ST_DONE;
                            state_next     = S_IDLE;
                        end
                    end else begin
                        cmd.link_wr  = 1'b1;
                        cmd.link_sel = stq_pkg::LW_PREV_ID;
                        state_next   = S_ARM_FIX;
                    end
                end else begin
                    cmd.prev_ld_cur = 1'b1;
                    cmd.cur_ld_next = 1'b1;
                    if (st.next_null) begin
                        cmd.link_wr  = 1'b1;
                        cmd.link_sel = stq_pkg::LW_CUR_ID;
                        state_next   = S_ARM_FIX;
                    end else begin
                        state_next = S_ARM_RD;
                    end
                end
            end
            S_ARM_FIX: begin
                if (!st.out_busy) begin
                    cmd.link_wr    = 1'b1;
                    cmd.link_sel   = stq_pkg::LW_ID_CUR;
                    cmd.out_ld     = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = stq_pkg::ST_DONE;
                    state_next     = S_IDLE;
                end
            end
            S_TICK_RD: begin
                cmd.rd_head = 1'b1;
                state_next  = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                cmd.rd_head = 1'b1;
                if (!st.out_busy) begin
                    if (st.expire) begin
                        cmd.out_ld       = st.pend_valid;
                        cmd.out_status   = stq_pkg::ST_EXPIRED;
                        cmd.pend_ld      = 1'b1;
                        cmd.flag_wr      = 1'b1;
                        cmd.flag_val     = stq_pkg::FL_ALLOC;
                        cmd.flag_sel     = stq_pkg::FA_HEAD;
                        cmd.head_ld_next = 1'b1;
                        state_next       = S_TICK_RD;
                    end else begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = st.pend_valid ? stq_pkg::ST_EXPIRED
                                                       : stq_pkg::ST_DONE;
                        cmd.pend_clr   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/software_timer_queue.sv -----
// top level of the software timer queue
// allocate: one flag slot scanned per cycle while the output is not held up
// arm: written straight into an empty list, else compared against each list entry in turn
// tick: expires due timers from the list head in order; free, bind and rejected requests answer from decode
// one transaction is worked on at a time, a waiting result holds off the next one
// sync active-low reset clears list and tick count; an init pass then frees the slots, one per cycle
`include "software_timer_queue_macros.svh"

module software_timer_queue #(
    parameter int NUM_TIMERS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // timer_id, timeout, dest_queue, data_tag, zero pad
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot, event_queue, event_data, zero pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    stq_pkg::stq_cmd_t  cmd;
    stq_pkg::stq_stat_t st;

    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    stq_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

    `STQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `STQ_ASSERT_IMPL(a_no_overwrite, cmd.out_ld, !st.out_busy)
    `STQ_ASSERT_IMPL(a_expired_has_pend, cmd.out_ld && cmd.out_status == stq_pkg::ST_EXPIRED, st.pend_valid)

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the software timer queue: stream stimulus and scoreboard
module tb_top;

    localparam int NSLOT = 64;
    localparam logic [6:0] NULL_IDX = 7'd64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [3:0]  queue;
        logic [31:0] data;
        logic        last;
    } timer_result_t;

    class timer_scoreboard;
        logic [1:0]    flags [NSLOT];
        logic [31:0]   due [NSLOT];
        logic [3:0]    dest [NSLOT];
        logic [31:0]   tag [NSLOT];
        logic [6:0]    nxt [NSLOT];
        logic [31:0]   ticks;
        logic [31:0]   soonest;
        logic [6:0]    head;
        timer_result_t pending_results[$];
        int errors;
        int results_seen;
        int expiries_seen;

        function new();
            foreach (flags[i]) begin
                flags[i] = stq_pkg::FL_FREE;
                due[i] = '0;
                dest[i] = '0;
                tag[i] = '0;
                nxt[i] = NULL_IDX;
            end
            ticks = '0;
            soonest = '1;
            head = NULL_IDX;
        endfunction

        function void push(logic [2:0] st, logic [5:0] sl, logic [3:0] q, logic [31:0] d);
            timer_result_t r;
            r.status = st;
            r.slot = sl;
            r.queue = q;
            r.data = d;
            r.last = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void insert_sorted(logic [5:0] id, logic [31:0] timeout);
            logic [31:0] dl;
            logic [6:0]  prev;
            logic [6:0]  cur;
            dl = ticks + timeout;
            due[id] = dl;
            flags[id] = stq_pkg::FL_RUN;
            if (head == NULL_IDX) begin
                head = {1'b0, id};
                nxt[id] = NULL_IDX;
                soonest = dl;
            end else if (dl <= due[head[5:0]]) begin
                nxt[id] = head;
                head = {1'b0, id};
                soonest = dl;
            end else begin
                prev = head;
                cur = nxt[prev[5:0]];
                while (cur != NULL_IDX && dl > due[cur[5:0]]) begin
                    prev = cur;
                    cur = nxt[cur[5:0]];
                end
                nxt[prev[5:0]] = {1'b0, id};
                nxt[id] = cur;
            end
        endfunction

        function void note_request(logic [2:0] req, logic [5:0] id, logic [31:0] timeout,
                                   logic [3:0] q, logic [31:0] d);
            int n;
            logic [5:0] h;
            n = pending_results.size();
            if (req == stq_pkg::REQ_ALLOC) begin
                int got;
                got = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (got < 0 && flags[i] == stq_pkg::FL_FREE) got = i;
                if (got < 0) push(stq_pkg::ST_NONE, '0, '0, '0);
                else begin
                    flags[got] = stq_pkg::FL_ALLOC;
                    push(stq_pkg::ST_GRANTED, got[5:0], '0, '0);
                end
            end else if (req == stq_pkg::REQ_TICK) begin
                ticks = ticks + 32'd1;
                if (soonest <= ticks) begin
                    while (head != NULL_IDX && due[head[5:0]] <= ticks) begin
                        h = head[5:0];
                        push(stq_pkg::ST_EXPIRED, h, dest[h], tag[h]);
                        flags[h] = stq_pkg::FL_ALLOC;
                        head = nxt[h];
                    end
                    soonest = (head != NULL_IDX) ? due[head[5:0]] : 32'hffffffff;
                end
                if (pending_results.size() == n) push(stq_pkg::ST_DONE, '0, '0, '0);
            end else if (req > stq_pkg::REQ_TICK) begin
                push(stq_pkg::ST_REJECTED, '0, '0, '0);
            end else if (req == stq_pkg::REQ_FREE) begin
                if (flags[id] == stq_pkg::FL_RUN) push(stq_pkg::ST_REJECTED, '0, '0, '0);
                else begin
                    flags[id] = stq_pkg::FL_FREE;
                    push(stq_pkg::ST_DONE, '0, '0, '0);
                end
            end else if (req == stq_pkg::REQ_BIND) begin
                dest[id] = q;
                tag[id] = d;
                push(stq_pkg::ST_DONE, '0, '0, '0);
            end else begin
                if (flags[id] == stq_pkg::FL_RUN) push(stq_pkg::ST_REJECTED, '0, '0, '0);
                else begin
                    insert_sorted(id, timeout);
                    push(stq_pkg::ST_DONE, '0, '0, '0);
                end
            end
            pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [2:0] st, logic [5:0] sl, logic [3:0] q,
                                   logic [31:0] d, logic lst);
            timer_result_t e;
            results_seen++;
            if (st == stq_pkg::ST_EXPIRED) expiries_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, status %0d", st);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st); errors++;
            end
            if (sl !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, sl); errors++;
            end
            if (q !== e.queue) begin
                $error("event_queue: expected %0d, got %0d", e.queue, q); errors++;
            end
            if (d !== e.data) begin
                $error("event_data: expected %h, got %h", e.data, d); errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, lst); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // timer_id, timeout, dest_queue, data_tag, zero pad
    logic [2:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // slot, event_queue, event_data, zero pad
    logic [2:0]  m_tuser;   // status
    logic        m_tlast;

    software_timer_queue #(.NUM_TIMERS(NSLOT)) i_dut (.*);

    timer_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  rx_hold;
    bit  bound [NSLOT];
    int  items_sent;
    int  quiet_cycles;

    initial begin
        aclk = 1'b0;
        sb = new();
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (rx_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[5:0], m_tdata[9:6], m_tdata[41:10], m_tlast);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] req, logic [5:0] id, logic [31:0] timeout,
                                logic [3:0] q, logic [31:0] d);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= req;
        s_tdata  <= {6'd0, d, q, timeout, id};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, id, timeout, q, d);
        if (req == stq_pkg::REQ_BIND) bound[id] = 1'b1;
        items_sent++;
    endtask

    function automatic logic [31:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(0, 8);
        if (r < 93) return $urandom;
        return 32'hffffffff - $urandom_range(0, 3);
    endfunction

    task automatic random_request();
        int r;
        logic [5:0] id;
        r = $urandom_range(99);
        id = 6'($urandom_range(0, NSLOT - 1));
        if (r < 18)
            send_request(stq_pkg::REQ_ALLOC, 6'($urandom), $urandom, 4'($urandom), $urandom);
        else if (r < 36)
            send_request(stq_pkg::REQ_BIND, id, $urandom, 4'($urandom), $urandom);
        else if (r < 64) begin
            // arm only slots that hold a binding
            for (int k = 0; k < 64 && !bound[id]; k++) id = 6'($urandom_range(0, NSLOT - 1));
            if (bound[id])
                send_request(stq_pkg::REQ_ARM, id, pick_timeout(), 4'($urandom), $urandom);
            else send_request(stq_pkg::REQ_BIND, id, $urandom, 4'($urandom), $urandom);
        end
        else if (r < 74)
            send_request(stq_pkg::REQ_FREE, id, $urandom, 4'($urandom), $urandom);
        else if (r < 96)
            send_request(stq_pkg::REQ_TICK, 6'($urandom), $urandom, 4'($urandom), $urandom);
        else send_request(3'($urandom_range(5, 7)), id, $urandom, 4'($urandom), $urandom);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        rx_hold = 1'b0;
        tx_idle_pct = 20;
        rx_idle_pct = 69;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: equal deadlines, busy timer, free slot cases, wrap, unknown requests
        send_request(stq_pkg::REQ_ALLOC, '0, '0, '0, '0);
        send_request(stq_pkg::REQ_ALLOC, '1, '1, '1, '1);
        send_request(stq_pkg::REQ_BIND, 6'd0, '0, 4'hf, 32'hffffffff);
        send_request(stq_pkg::REQ_BIND, 6'd1, '1, 4'h0, 32'h0);
        send_request(stq_pkg::REQ_ARM, 6'd0, 32'd0, '0, '0);
        send_request(stq_pkg::REQ_ARM, 6'd1, 32'd0, '0, '0);
        send_request(stq_pkg::REQ_ARM, 6'd0, 32'd5, '0, '0);
        send_request(stq_pkg::REQ_FREE, 6'd0, '0, '0, '0);
        send_request(stq_pkg::REQ_TICK, '0, '0, '0, '0);
        send_request(stq_pkg::REQ_TICK, '1, '1, '1, '1);
        send_request(stq_pkg::REQ_FREE, 6'd5, '0, '0, '0);
        send_request(stq_pkg::REQ_BIND, 6'd63, '0, 4'ha, 32'h5a5a_a5a5);
        send_request(stq_pkg::REQ_ARM, 6'd63, 32'hffffffff, '0, '0);
        send_request(stq_pkg::REQ_TICK, '0, '0, '0, '0);
        send_request(3'd5, 6'd2, '0, '0, '0);
        send_request(3'd6, '0, '0, '0, '0);
        send_request(3'd7, '1, '1, '1, '1);
        send_request(stq_pkg::REQ_FREE, 6'd1, '0, '0, '0);
        send_request(stq_pkg::REQ_ALLOC, '0, '0, '0, '0);

        // exhaust the pool once, then random traffic
        for (int i = 0; i < 66; i++) send_request(stq_pkg::REQ_ALLOC, '0, '0, '0, '0);
        for (int i = 0; i < 60; i++) random_request();
        tx_idle_pct = 69;
        rx_idle_pct = 20;
        for (int i = 0; i < 60; i++) random_request();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 60; i++) random_request();
        @(negedge aclk) s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("tb_top: %0d requests, %0d results checked, %0d timer expiries",
                 items_sent, sb.results_seen, sb.expiries_seen);
        $display("tb_top: pool exhaustion, sorted arming, wrap, busy and unknown requests");
        if (sb.errors == 0 && sb.pending_results.size() == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule
